### design/bpc_pkg.sv
`default_nettype none
package bpc_pkg;

  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int AGE_WIDTH_DEF = 16;

  localparam logic [CFG_W-1:0] LONG_RESET = 16'd80;
  localparam logic [CFG_W-1:0] GAP_RESET  = 16'd30;

  typedef logic [2:0] btn_t;
  localparam btn_t BTN_NONE = 3'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONG = 8'd0,
    REG_GAP  = 8'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SINGLE = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_LONG   = 3'd3,
    EV_WAKE   = 3'd4
  } ev_t;

  function automatic btn_t encode_buttons(input logic [3:0] b);
    btn_t r;
    if (b[0]) begin
      r = 3'd0;
    end else if (b[1]) begin
      r = 3'd1;
    end else if (b[2]) begin
      r = 3'd2;
    end else if (b[3]) begin
      r = 3'd3;
    end else begin
      r = BTN_NONE;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/button_press_classifier.sv
// a result word is registered and appears in the cycle after its sample word is accepted
// throughput: one sample per cycle; the output register takes a new result
//   in the cycle its previous one is taken, so ready only drops on a stall
// reset (rst_n low, synchronous): no button held, nothing pending, no wake
//   swallowing, limits back to 80 and 30 ticks, output register empty
`default_nettype none
module button_press_classifier #(
  parameter int AGE_WIDTH = bpc_pkg::AGE_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    in_buttons_down,
  input  wire logic                          in_display_on,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_press_event,
  output logic [1:0]                         out_event_button,
  output logic                               out_activity,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bpc_pkg::CFG_W-1:0]     cfg_data
);
  import bpc_pkg::*;

  localparam int CMP_W = (AGE_WIDTH > CFG_W) ? AGE_WIDTH : CFG_W;
  localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

  logic [CFG_W-1:0]     long_r, gap_r;
  btn_t                 held_r, held_nxt;
  btn_t                 pend_r, pend_nxt;
  logic [AGE_WIDTH-1:0] press_age_r, press_age_nxt;
  logic [AGE_WIDTH-1:0] rel_age_r, rel_age_nxt;
  logic                 await_r, await_nxt;
  logic                 swal_r, swal_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ev_t                  ev_r, ev_nxt;
  logic [1:0]           eb_r, eb_nxt;
  logic                 act_r, act_nxt;

  logic                 in_acc;
  btn_t                 cur;
  logic [CMP_W-1:0]     pa_x, ra_x, long_x, gap_x;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cur       = encode_buttons(in_buttons_down);

  assign out_valid        = out_valid_r;
  assign out_press_event  = ev_r;
  assign out_event_button = eb_r;
  assign out_activity     = act_r;
  assign out_valid_nxt    = in_acc || (out_valid_r && !out_ready);

  always_comb begin
    held_nxt      = held_r;
    pend_nxt      = pend_r;
    await_nxt     = await_r;
    swal_nxt      = swal_r;
    ev_nxt        = EV_NONE;
    eb_nxt        = 2'd0;
    act_nxt       = 1'b0;
    press_age_nxt = press_age_r;
    rel_age_nxt   = rel_age_r;

    // ages advance first, saturating
    if (await_r && rel_age_r != AGE_MAX) begin
      rel_age_nxt = rel_age_r + 1'b1;
    end
    if (held_r != BTN_NONE && press_age_r != AGE_MAX) begin
      press_age_nxt = press_age_r + 1'b1;
    end

    pa_x   = CMP_W'(press_age_nxt);
    long_x = CMP_W'(long_r);
    gap_x  = CMP_W'(gap_r);

    if (swal_r && in_buttons_down != 4'd0) begin
      // still swallowing after a wake press
      ra_x = CMP_W'(rel_age_nxt);
    end else begin
      swal_nxt = 1'b0;
      if (cur != BTN_NONE && held_r == BTN_NONE && !in_display_on) begin
        swal_nxt = 1'b1;
        ev_nxt   = EV_WAKE;
        eb_nxt   = cur[1:0];
        ra_x     = CMP_W'(rel_age_nxt);
      end else begin
        if (cur != BTN_NONE && held_r == BTN_NONE) begin
          held_nxt      = cur;
          press_age_nxt = '0;
          act_nxt       = 1'b1;
        end
        ra_x = CMP_W'(rel_age_nxt);
        if (cur == BTN_NONE && held_r != BTN_NONE) begin
          if (pa_x > long_x) begin
            ev_nxt    = EV_LONG;
            eb_nxt    = held_r[1:0];
            await_nxt = 1'b0;
            pend_nxt  = BTN_NONE;
          end else if (await_r && ra_x < gap_x && held_r == pend_r) begin
            ev_nxt    = EV_DOUBLE;
            eb_nxt    = held_r[1:0];
            await_nxt = 1'b0;
            pend_nxt  = BTN_NONE;
          end else begin
            await_nxt   = 1'b1;
            pend_nxt    = held_r;
            rel_age_nxt = '0;
          end
          held_nxt = BTN_NONE;
        end
        // gap expiry
        if (await_nxt && CMP_W'(rel_age_nxt) >= gap_x) begin
          ev_nxt    = EV_SINGLE;
          eb_nxt    = pend_nxt[1:0];
          await_nxt = 1'b0;
          pend_nxt  = BTN_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r      <= LONG_RESET;
      gap_r       <= GAP_RESET;
      held_r      <= BTN_NONE;
      pend_r      <= BTN_NONE;
      press_age_r <= '0;
      rel_age_r   <= '0;
      await_r     <= 1'b0;
      swal_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_LONG: long_r <= cfg_data;
          REG_GAP:  gap_r  <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc) begin
        held_r      <= held_nxt;
        pend_r      <= pend_nxt;
        press_age_r <= press_age_nxt;
        rel_age_r   <= rel_age_nxt;
        await_r     <= await_nxt;
        swal_r      <= swal_nxt;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ev_r  <= ev_nxt;
      eb_r  <= eb_nxt;
      act_r <= act_nxt;
    end
  end

endmodule
`default_nettype wire

### design/bpc_checker.sv
`default_nettype none
module bpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_press_event,
  input wire logic [1:0] out_event_button,
  input wire logic       out_activity
);
  import bpc_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted sample gave no result word");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_press_event)
      && $stable(out_event_button) && $stable(out_activity))
    else $error("stalled result changed");

  a_none_btn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_event == EV_NONE |-> out_event_button == 2'd0)
    else $error("button reported without event");

  a_wake_act: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_press_event == EV_WAKE |-> !out_activity)
    else $error("wake press flagged activity");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_press_event <= EV_WAKE)
    else $error("undefined event code");

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_press_event  (out_press_event),
  .out_event_button (out_event_button),
  .out_activity     (out_activity)
);
`default_nettype wire
